// ===== hw/rtl/zcrs_pkg.sv =====
`default_nettype none

package zcrs_pkg;

    localparam int unsigned CNT_W       = 16;
    localparam int unsigned TYPE_W      = 3;
    localparam int unsigned POL_W       = 2;
    localparam int unsigned APB_ADDR_W  = 4;
    localparam int unsigned APB_DATA_W  = 32;
    localparam int unsigned S_TDATA_W   = 8;
    localparam int unsigned M_TDATA_W   = 56;

    typedef enum logic [TYPE_W-1:0] {
        EV_RANGE   = 3'd0,
        EV_VALID   = 3'd1,
        EV_LOST    = 3'd2,
        EV_INVALID = 3'd3,
        EV_COMMAND = 3'd4
    } ev_type_t;

    typedef enum logic [POL_W-1:0] {
        POL_USER = 2'd0,
        POL_ON   = 2'd1,
        POL_OFF  = 2'd2
    } policy_t;

    typedef enum logic [1:0] {
        REG_ACTIVE_LEVEL   = 2'd0,
        REG_OFF_AFTER_LOSS = 2'd1,
        REG_POLICY         = 2'd2,
        REG_PULSE_WAVE     = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic             active_level;
        logic             off_after_loss;
        logic [POL_W-1:0] out_of_range_policy;
        logic             pulse_wave_mode;
    } cfg_t;

    typedef struct packed {
        logic [TYPE_W-1:0] req_type;
        logic              edge_rising;
        logic              command_on;
    } item_t;

    typedef struct packed {
        logic [CNT_W-1:0] switch_on_events;
        logic [CNT_W-1:0] switch_off_events;
        logic [CNT_W-1:0] out_of_range_events;
        logic             request_pending;
        logic             relay_pin;
    } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/zcrs_cfg.sv =====
`default_nettype none

module zcrs_cfg (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [zcrs_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [zcrs_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [zcrs_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                   pready,
    output zcrs_pkg::cfg_t                         cfg
);

    zcrs_pkg::cfg_t cfg_reg;
    zcrs_pkg::cfg_t cfg_next;
    logic           wr_en;
    logic [1:0]     idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;
    assign idx    = paddr[3:2];
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (idx)
                zcrs_pkg::REG_ACTIVE_LEVEL:   cfg_next.active_level = pwdata[0];
                zcrs_pkg::REG_OFF_AFTER_LOSS: cfg_next.off_after_loss = pwdata[0];
                zcrs_pkg::REG_POLICY:
                    cfg_next.out_of_range_policy = pwdata[zcrs_pkg::POL_W-1:0];
                zcrs_pkg::REG_PULSE_WAVE:     cfg_next.pulse_wave_mode = pwdata[0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (idx)
            zcrs_pkg::REG_ACTIVE_LEVEL:   prdata[0] = cfg_reg.active_level;
            zcrs_pkg::REG_OFF_AFTER_LOSS: prdata[0] = cfg_reg.off_after_loss;
            zcrs_pkg::REG_POLICY:
                prdata[zcrs_pkg::POL_W-1:0] = cfg_reg.out_of_range_policy;
            zcrs_pkg::REG_PULSE_WAVE:     prdata[0] = cfg_reg.pulse_wave_mode;
            default: prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.active_level        <= 1'b1;
            cfg_reg.off_after_loss      <= 1'b1;
            cfg_reg.out_of_range_policy <= zcrs_pkg::POL_OFF;
            cfg_reg.pulse_wave_mode     <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/zcrs_core.sv =====
`default_nettype none

module zcrs_core (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            en,
    input  wire zcrs_pkg::item_t item,
    input  wire zcrs_pkg::cfg_t  cfg,
    output zcrs_pkg::result_t    result
);

    logic                       pending_reg, pending_next;
    logic                       wanted_reg, wanted_next;
    logic                       pin_reg, pin_next;
    logic [zcrs_pkg::CNT_W-1:0] range_cnt_reg, range_cnt_next;
    logic [zcrs_pkg::CNT_W-1:0] off_cnt_reg, off_cnt_next;
    logic [zcrs_pkg::CNT_W-1:0] on_cnt_reg, on_cnt_next;
    logic                       do_cross;
    logic                       rising;
    logic                       lvl_on;
    logic                       lvl_off;

    assign rising  = item.edge_rising;
    assign lvl_on  = cfg.active_level;
    assign lvl_off = ~cfg.active_level;

    always_comb begin
        pending_next   = pending_reg;
        wanted_next    = wanted_reg;
        pin_next       = pin_reg;
        range_cnt_next = range_cnt_reg;
        off_cnt_next   = off_cnt_reg;
        on_cnt_next    = on_cnt_reg;
        do_cross       = 1'b0;

        case (item.req_type)
            zcrs_pkg::EV_RANGE: begin
                range_cnt_next = range_cnt_reg + 1'b1;
                if (rising) begin
                    if (cfg.out_of_range_policy == zcrs_pkg::POL_ON) begin
                        pin_next = lvl_on;
                    end else if (cfg.pulse_wave_mode &&
                                 cfg.out_of_range_policy == zcrs_pkg::POL_OFF) begin
                        pin_next = lvl_off;
                    end
                end else if (cfg.out_of_range_policy == zcrs_pkg::POL_OFF) begin
                    pin_next = lvl_off;
                end
            end
            zcrs_pkg::EV_VALID: begin
                do_cross = 1'b1;
            end
            zcrs_pkg::EV_LOST: begin
                if (cfg.off_after_loss) begin
                    pin_next     = lvl_off;
                    pending_next = 1'b0;
                end
            end
            zcrs_pkg::EV_INVALID: begin
                do_cross = (cfg.out_of_range_policy == zcrs_pkg::POL_USER);
            end
            zcrs_pkg::EV_COMMAND: begin
                wanted_next  = item.command_on;
                pending_next = 1'b1;
            end
            default: do_cross = 1'b0;
        endcase

        if (do_cross && pending_reg) begin
            if (wanted_reg) begin
                if (rising) begin
                    pin_next     = lvl_on;
                    pending_next = 1'b0;
                    on_cnt_next  = on_cnt_reg + 1'b1;
                end
            end else if (!rising || cfg.pulse_wave_mode) begin
                pin_next     = lvl_off;
                pending_next = 1'b0;
                off_cnt_next = off_cnt_reg + 1'b1;
            end
        end
    end

    assign result.relay_pin           = pin_next;
    assign result.request_pending     = pending_next;
    assign result.out_of_range_events = range_cnt_next;
    assign result.switch_off_events   = off_cnt_next;
    assign result.switch_on_events    = on_cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg   <= 1'b0;
            wanted_reg    <= 1'b0;
            pin_reg       <= 1'b0;
            range_cnt_reg <= '0;
            off_cnt_reg   <= '0;
            on_cnt_reg    <= '0;
        end else if (en) begin
            pending_reg   <= pending_next;
            wanted_reg    <= wanted_next;
            pin_reg       <= pin_next;
            range_cnt_reg <= range_cnt_next;
            off_cnt_reg   <= off_cnt_next;
            on_cnt_reg    <= on_cnt_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/zero_cross_relay_switch_top.sv =====
// Channel   Dir  Handshake          Payload
// s_        in   s_tvalid/s_tready  s_tuser: req_type; s_tdata: edge_rising, command_on
// m_        out  m_tvalid/m_tready  m_tdata: pin, pending, 3 x 16-bit event counters
// apb       in   psel/penable       4 config registers at 0x0, 0x4, 0x8, 0xC
//
// One transfer in, one transfer out per item; throughput 1 item/cycle while m_tready is high.
// Each item passes the input register, then the state update into the output register.
// Synchronous active-low reset clears both valid flags and the state, and sets config to its defaults.
// m_tready low holds the output; the input register still takes one more item.
`default_nettype none

module zero_cross_relay_switch_top (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // [0] edge_rising, [1] command_on, [7:2] zero
    input  wire logic [zcrs_pkg::S_TDATA_W-1:0]    s_tdata,
    // [2:0] req_type
    input  wire logic [zcrs_pkg::TYPE_W-1:0]       s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [0] relay_pin, [1] request_pending, [17:2] out_of_range_events,
    // [33:18] switch_off_events, [49:34] switch_on_events, [55:50] zero
    output logic      [zcrs_pkg::M_TDATA_W-1:0]    m_tdata,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [zcrs_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [zcrs_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [zcrs_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                   pready
);

    localparam int unsigned RES_W = $bits(zcrs_pkg::result_t);

    zcrs_pkg::cfg_t    cfg;
    zcrs_pkg::item_t   in_item_reg;
    logic              in_valid_reg;
    zcrs_pkg::result_t result;
    zcrs_pkg::result_t out_res_reg;
    logic              out_valid_reg;
    logic              advance;
    logic              step;

    assign advance  = !out_valid_reg || m_tready;
    assign step     = advance && in_valid_reg;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(zcrs_pkg::M_TDATA_W - RES_W){1'b0}}, out_res_reg};

    zcrs_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    zcrs_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (step),
        .item    (in_item_reg),
        .cfg     (cfg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg.req_type    <= s_tuser;
            in_item_reg.edge_rising <= s_tdata[0];
            in_item_reg.command_on  <= s_tdata[1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_res_reg <= result;
        end
    end

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !out_valid_reg |-> s_tready)
        else $error("input stalled with empty output register");

    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !in_valid_reg) |=> !m_tvalid)
        else $error("result repeated after transfer");

    a_cmd_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && in_item_reg.req_type == zcrs_pkg::EV_COMMAND) |=> m_tdata[1])
        else $error("command did not leave a pending request");

    a_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> in_valid_reg)
        else $error("accepted item lost at input register");

endmodule

`default_nettype wire

// ===== bench/zero_cross_relay_switch_top_test.sv =====
`timescale 1ns / 1ps

module zero_cross_relay_switch_top_test;
    import zcrs_pkg::*;

    localparam logic [POL_W-1:0] POL_SPARE = 2'd3;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 8;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata = '0;      // [0] edge_rising, [1] command_on, rest zero
    logic [TYPE_W-1:0]      s_tuser = '0;      // [2:0] req_type
    logic                   m_tvalid;
    logic                   m_tready = 1'b1;
    logic [M_TDATA_W-1:0]   m_tdata;           // [0] relay_pin, [1] request_pending,
                                               // [17:2] out_of_range_events,
                                               // [33:18] switch_off_events,
                                               // [49:34] switch_on_events, rest zero
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr = '0;
    logic [APB_DATA_W-1:0]  pwdata = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    zero_cross_relay_switch_top uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // relay state as the block should hold it
    cfg_t             relay_cfg;
    logic             req_pending = 1'b0;
    logic             req_on = 1'b0;
    logic             pin_level = 1'b0;
    logic [CNT_W-1:0] range_cnt = '0;
    logic [CNT_W-1:0] off_cnt = '0;
    logic [CNT_W-1:0] on_cnt = '0;

    result_t relay_status_q[$];
    int      error_count = 0;
    int      quiet_cycles = 0;
    bit      bursts_on = 1'b0;
    int      stall_left = 0;
    bit      edge_phase = 1'b0;

    function automatic void zero_crossing(logic rising);
        if (!req_pending)
            return;
        if (req_on) begin
            if (rising) begin
                pin_level = relay_cfg.active_level;
                req_pending = 1'b0;
                on_cnt = on_cnt + 1'b1;
            end
        end else if (!rising || relay_cfg.pulse_wave_mode) begin
            pin_level = ~relay_cfg.active_level;
            req_pending = 1'b0;
            off_cnt = off_cnt + 1'b1;
        end
    endfunction

    function automatic result_t relay_update(logic [TYPE_W-1:0] kind, logic rising, logic cmd);
        result_t r;
        case (kind)
            EV_RANGE: begin
                range_cnt = range_cnt + 1'b1;
                if (rising) begin
                    if (relay_cfg.out_of_range_policy == POL_ON)
                        pin_level = relay_cfg.active_level;
                    else if (relay_cfg.pulse_wave_mode && relay_cfg.out_of_range_policy == POL_OFF)
                        pin_level = ~relay_cfg.active_level;
                end else if (relay_cfg.out_of_range_policy == POL_OFF) begin
                    pin_level = ~relay_cfg.active_level;
                end
            end
            EV_VALID: zero_crossing(rising);
            EV_LOST: begin
                if (relay_cfg.off_after_loss) begin
                    pin_level = ~relay_cfg.active_level;
                    req_pending = 1'b0;
                end
            end
            EV_INVALID: begin
                if (relay_cfg.out_of_range_policy == POL_USER)
                    zero_crossing(rising);
            end
            EV_COMMAND: begin
                req_on = cmd;
                req_pending = 1'b1;
            end
            default: ;
        endcase
        r.relay_pin = pin_level;
        r.request_pending = req_pending;
        r.out_of_range_events = range_cnt;
        r.switch_off_events = off_cnt;
        r.switch_on_events = on_cnt;
        return r;
    endfunction

    function automatic void check_field(string name, logic [CNT_W-1:0] want,
                                        logic [CNT_W-1:0] got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    // result checker, prediction on each input transfer, watchdog
    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[49:0];
                if (relay_status_q.size() == 0) begin
                    $error("unexpected result transfer: %h", m_tdata);
                    error_count++;
                end else begin
                    want = relay_status_q.pop_front();
                    check_field("relay_pin", CNT_W'(want.relay_pin), CNT_W'(got.relay_pin));
                    check_field("request_pending", CNT_W'(want.request_pending),
                                CNT_W'(got.request_pending));
                    check_field("out_of_range_events", want.out_of_range_events,
                                got.out_of_range_events);
                    check_field("switch_off_events", want.switch_off_events,
                                got.switch_off_events);
                    check_field("switch_on_events", want.switch_on_events,
                                got.switch_on_events);
                end
            end
            if (s_tvalid && s_tready)
                relay_status_q.push_back(relay_update(s_tuser, s_tdata[0], s_tdata[1]));
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("zero_cross_relay_switch_top_test: done, errors");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // receiver back-pressure
    always @(posedge aclk) begin
        if (stall_left > 1) begin
            stall_left <= stall_left - 1;
        end else if (bursts_on && $urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(1, 11);
            m_tready <= 1'b0;
        end else begin
            stall_left <= 0;
            m_tready <= 1'b1;
        end
    end

    task automatic send_event(logic [TYPE_W-1:0] kind, logic rising, logic cmd);
        if (bursts_on && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {{(S_TDATA_W - 2){1'b0}}, cmd, rising};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (relay_status_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic reg_write(reg_idx_t idx, logic [APB_DATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= APB_ADDR_W'({idx, 2'b00});
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_ACTIVE_LEVEL:   relay_cfg.active_level = value[0];
            REG_OFF_AFTER_LOSS: relay_cfg.off_after_loss = value[0];
            REG_POLICY:         relay_cfg.out_of_range_policy = value[POL_W-1:0];
            REG_PULSE_WAVE:     relay_cfg.pulse_wave_mode = value[0];
            default: ;
        endcase
    endtask

    task automatic set_config(logic level, logic loss, logic [POL_W-1:0] pol, logic pulse);
        wait_idle();
        reg_write(REG_ACTIVE_LEVEL, APB_DATA_W'(level));
        reg_write(REG_OFF_AFTER_LOSS, APB_DATA_W'(loss));
        reg_write(REG_POLICY, APB_DATA_W'(pol));
        reg_write(REG_PULSE_WAVE, APB_DATA_W'(pulse));
    endtask

    task automatic test_switching();
        send_event(EV_VALID, 1'b1, 1'b1);      // nothing pending
        send_event(EV_COMMAND, 1'b1, 1'b1);
        send_event(EV_VALID, 1'b0, 1'b0);      // on waits for rising edge
        send_event(EV_VALID, 1'b1, 1'b0);
        send_event(EV_COMMAND, 1'b0, 1'b0);
        send_event(EV_VALID, 1'b1, 1'b1);      // off waits for falling edge
        send_event(EV_VALID, 1'b0, 1'b0);
    endtask

    task automatic test_pulse_wave();
        set_config(1'b1, 1'b1, POL_OFF, 1'b1);
        send_event(EV_COMMAND, 1'b0, 1'b0);
        send_event(EV_VALID, 1'b1, 1'b0);      // off on rising edge
        send_event(EV_COMMAND, 1'b0, 1'b1);
    endtask

    task automatic test_policies();
        set_config(1'b1, 1'b1, POL_USER, 1'b0);
        send_event(EV_INVALID, 1'b0, 1'b1);
        send_event(EV_INVALID, 1'b1, 1'b0);    // user control on invalid edge
        set_config(1'b1, 1'b1, POL_ON, 1'b0);
        send_event(EV_RANGE, 1'b0, 1'b1);      // force on, falling: count only
        send_event(EV_RANGE, 1'b1, 1'b0);
        set_config(1'b1, 1'b1, POL_OFF, 1'b0);
        send_event(EV_RANGE, 1'b1, 1'b1);      // force off, rising: no drive
        send_event(EV_RANGE, 1'b0, 1'b0);
        set_config(1'b1, 1'b1, POL_ON, 1'b0);
        send_event(EV_RANGE, 1'b1, 1'b0);
        set_config(1'b1, 1'b1, POL_OFF, 1'b1);
        send_event(EV_RANGE, 1'b1, 1'b0);      // force off, rising, pulse wave
        set_config(1'b1, 1'b1, POL_SPARE, 1'b0);
        send_event(EV_COMMAND, 1'b1, 1'b1);
        send_event(EV_INVALID, 1'b1, 1'b0);
        send_event(EV_RANGE, 1'b1, 1'b1);
        send_event(EV_RANGE, 1'b0, 1'b1);
    endtask

    task automatic test_signal_loss();
        send_event(EV_LOST, 1'b1, 1'b1);       // drops relay, clears request
        set_config(1'b1, 1'b0, POL_USER, 1'b0);
        send_event(EV_COMMAND, 1'b0, 1'b1);
        send_event(EV_VALID, 1'b1, 1'b0);
        send_event(EV_COMMAND, 1'b1, 1'b0);
        send_event(EV_LOST, 1'b0, 1'b0);       // kept
    endtask

    task automatic test_active_level();
        set_config(1'b0, 1'b1, POL_USER, 1'b0);
        send_event(EV_VALID, 1'b1, 1'b0);      // pin held until next drive
        send_event(EV_VALID, 1'b0, 1'b1);
        for (int t = int'(EV_COMMAND) + 1; t < 2 ** TYPE_W; t++)
            send_event(TYPE_W'(t), t[0], t[1]);
    endtask

    function automatic logic [TYPE_W-1:0] pick_event();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 22)
            return EV_COMMAND;
        else if (roll < 60)
            return EV_VALID;
        else if (roll < 75)
            return EV_INVALID;
        else if (roll < 86)
            return EV_RANGE;
        else if (roll < 94)
            return EV_LOST;
        return TYPE_W'($urandom_range(int'(EV_COMMAND) + 1, 2 ** TYPE_W - 1));
    endfunction

    task automatic test_random();
        logic rising;
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: set_config(1'b0, 1'b0, POL_USER, 1'b0);
                1: set_config(1'b1, 1'b1, POL_SPARE, 1'b1);
                2: set_config(1'b1, 1'b0, POL_USER, 1'b1);
                default: set_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                    POL_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
            endcase
            for (int n = 0; n < 250; n++) begin
                if (n % 50 == 0)
                    bursts_on = (phase < 5) && ($urandom_range(0, 3) != 0);
                // mains edges mostly alternate
                edge_phase = ~edge_phase;
                rising = ($urandom_range(0, 9) == 0) ? 1'($urandom_range(0, 1)) : edge_phase;
                send_event(pick_event(), rising, 1'($urandom_range(0, 1)));
            end
        end
        bursts_on = 1'b0;
    endtask

    initial begin
        relay_cfg.active_level = 1'b1;
        relay_cfg.off_after_loss = 1'b1;
        relay_cfg.out_of_range_policy = POL_OFF;
        relay_cfg.pulse_wave_mode = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_switching();
        test_pulse_wave();
        test_policies();
        test_signal_loss();
        test_active_level();
        test_random();
        wait_idle();
        if (relay_status_q.size() != 0) begin
            $error("%0d expected results never arrived", relay_status_q.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("zero_cross_relay_switch_top_test: done, clean");
        end else begin
            $display("zero_cross_relay_switch_top_test: done, errors");
        end
        $finish;
    end

endmodule
